>>> rtl/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
`default_nettype none

package tga_rle_pkg;

    localparam int unsigned PIXEL_W = 32;
    localparam int unsigned COUNT_W = 8;

    localparam logic [7:0] COUNT_MASK = 8'h7f;
    localparam logic [7:0] RUN_BIT    = 8'h80;

    localparam logic [1:0] REG_PIXEL_BYTES_MODE = 2'd0;
    localparam logic [1:0] REG_RLE_ENABLE       = 2'd1;
    localparam logic [1:0] REG_PIXEL_TOTAL      = 2'd2;

    localparam logic [1:0] MODE_ONE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_THREE_BYTE = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC_ROOM,
        ST_CALC_MIN,
        ST_EMIT
    } state_t;

    typedef enum logic {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [PIXEL_W-1:0] a;
        logic [PIXEL_W-1:0] b;
    } alu_req_t;

endpackage

`default_nettype wire

>>> rtl/tga_rle_alu.sv
// Shared 32-bit add/subtract unit used by the decoder sequencer.
`default_nettype none

module tga_rle_alu (
    input  var tga_rle_pkg::alu_req_t req,
    output logic [31:0]               result,
    output logic                      carry
);
    import tga_rle_pkg::*;

    logic [PIXEL_W:0] wide;

    always_comb
    begin
        unique case (req.op)
            ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            default: wide = '0;
        endcase
        result = wide[PIXEL_W-1:0];
        carry  = wide[PIXEL_W];
    end

endmodule

`default_nettype wire

>>> rtl/tga_rle_pixel_decoder_core.sv
// Top level of the TGA run-length pixel decoder.
//
// Usage: feed the image data bytes that follow the TGA header on the input
// channel (in_valid / in_stall / data_byte). Decoded pixels leave on the output
// channel, one or two identical run pixels per result, with the linear index of
// the first one. A byte that is a packet header or does not finish a pixel is
// taken while idle and gives no result. A byte that finishes a pixel passes
// through the shared add/subtract unit (room left, then clip to the packet),
// then gives ceil(n/2) results, one per cycle while the receiver does not
// stall. in_stall stays high from the finishing byte until its last result is
// taken. While out_stall is high the current result holds. Bytes after the
// pixel total are taken and dropped. Reset or any configuration write
// (wr_en / wr_index / wr_data) clears the decode state; writes belong to idle
// periods only.
`default_nettype none

module tga_rle_pixel_decoder_core #(
    parameter int unsigned MAX_PIXEL_BYTES = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [31:0] wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      first_pixel,
    output logic [31:0]      second_pixel,
    output logic [1:0]       pixel_count,
    output logic [31:0]      first_index,
    output logic             last_of_run,
    output logic             image_done,
    output logic             overrun
);
    import tga_rle_pkg::*;

    localparam int unsigned GATHER_W = 8 * MAX_PIXEL_BYTES;
    localparam logic [2:0]  MAX_BPP  = 3'(MAX_PIXEL_BYTES);

    state_t               state_reg, state_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 rle_reg, rle_next;
    logic [31:0]          total_reg, total_next;
    logic                 expect_hdr_reg, expect_hdr_next;
    logic                 is_run_reg, is_run_next;
    logic [COUNT_W-1:0]   packet_left_reg, packet_left_next;
    logic [1:0]           byte_pos_reg, byte_pos_next;
    logic [GATHER_W-1:0]  gather_reg, gather_next;
    logic [31:0]          emitted_reg, emitted_next;
    logic                 finished_reg, finished_next;
    logic                 overrun_reg, overrun_next;
    logic [31:0]          pix_reg, pix_next;
    logic [31:0]          room_reg, room_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [31:0]          index_reg, index_next;
    logic                 reach_reg, reach_next;

    alu_req_t             alu_req;
    logic [31:0]          alu_result;
    logic                 alu_carry;

    logic                 in_accept;
    logic                 out_accept;
    logic [2:0]           bpp_raw;
    logic [2:0]           bpp;
    logic                 pixel_done;
    logic [31:0]          merged;
    logic [COUNT_W-1:0]   want;
    logic [COUNT_W-1:0]   e_cnt;
    logic                 e_lt_want;
    logic                 reach;
    logic [1:0]           cnt;
    logic                 last_result;
    logic [COUNT_W-1:0]   left_after_pkt;

    tga_rle_alu u_alu (
        .req    (alu_req),
        .result (alu_result),
        .carry  (alu_carry)
    );

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;

    always_comb
    begin
        unique case (mode_reg)
            MODE_ONE_BYTE:   bpp_raw = 3'd1;
            MODE_THREE_BYTE: bpp_raw = 3'd3;
            default:         bpp_raw = 3'd4;
        endcase
        bpp = (bpp_raw > MAX_BPP) ? MAX_BPP : bpp_raw;
    end

    assign merged     = 32'(gather_reg) | (32'(data_byte) << {byte_pos_reg, 3'b000});
    assign pixel_done = !((3'(byte_pos_reg) + 3'd1) < bpp);

    assign want = (rle_reg && is_run_reg) ? packet_left_reg : COUNT_W'(1);
    assign cnt  = (left_reg >= COUNT_W'(2)) ? 2'd2 : 2'd1;
    assign last_result = (left_reg <= COUNT_W'(2));

    // Clip the packet to the room left in the image.
    always_comb
    begin
        if (alu_carry)
        begin
            e_cnt     = want;
            e_lt_want = 1'b0;
            reach     = 1'b0;
        end
        else
        begin
            e_cnt     = room_reg[COUNT_W-1:0];
            e_lt_want = (alu_result != 32'd0);
            reach     = 1'b1;
        end
    end

    assign left_after_pkt = is_run_reg ? '0 : packet_left_reg - COUNT_W'(1);

    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.a  = total_reg;
        alu_req.b  = emitted_reg;
        unique case (state_reg)
            ST_CALC_MIN:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = 32'(want);
                alu_req.b  = room_reg;
            end
            ST_EMIT:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = index_reg;
                alu_req.b  = 32'(cnt);
            end
            default:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = total_reg;
                alu_req.b  = emitted_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_accept && !finished_reg && !(rle_reg && expect_hdr_reg) && pixel_done)
                    state_next = ST_CALC_ROOM;
            ST_CALC_ROOM:
                state_next = ST_CALC_MIN;
            ST_CALC_MIN:
                state_next = (e_cnt == '0) ? ST_IDLE : ST_EMIT;
            ST_EMIT:
                if (out_accept && last_result)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (wr_en)
            state_next = ST_IDLE;
    end

    // Datapath and control register updates.
    always_comb
    begin
        mode_next        = mode_reg;
        rle_next         = rle_reg;
        total_next       = total_reg;
        expect_hdr_next  = expect_hdr_reg;
        is_run_next      = is_run_reg;
        packet_left_next = packet_left_reg;
        byte_pos_next    = byte_pos_reg;
        gather_next      = gather_reg;
        emitted_next     = emitted_reg;
        finished_next    = finished_reg;
        overrun_next     = overrun_reg;
        pix_next         = pix_reg;
        room_next        = room_reg;
        left_next        = left_reg;
        index_next       = index_reg;
        reach_next       = reach_reg;

        unique case (state_reg)
            ST_IDLE:
                if (in_accept && !finished_reg)
                begin
                    if (rle_reg && expect_hdr_reg)
                    begin
                        packet_left_next = COUNT_W'(data_byte & COUNT_MASK) + COUNT_W'(1);
                        is_run_next      = (data_byte & RUN_BIT) != 8'd0;
                        expect_hdr_next  = 1'b0;
                        byte_pos_next    = '0;
                        gather_next      = '0;
                    end
                    else if (!pixel_done)
                    begin
                        gather_next   = merged[GATHER_W-1:0];
                        byte_pos_next = byte_pos_reg + 2'd1;
                    end
                    else
                    begin
                        pix_next      = 32'(merged[GATHER_W-1:0]);
                        gather_next   = '0;
                        byte_pos_next = '0;
                    end
                end
            ST_CALC_ROOM:
                room_next = alu_result;
            ST_CALC_MIN:
            begin
                left_next  = e_cnt;
                index_next = emitted_reg;
                reach_next = reach;
                if (rle_reg)
                begin
                    packet_left_next = left_after_pkt;
                    expect_hdr_next  = (left_after_pkt == '0);
                end
                if (reach)
                    finished_next = 1'b1;
                if (rle_reg && reach &&
                    (e_lt_want || (!is_run_reg && packet_left_reg != COUNT_W'(1))))
                    overrun_next = 1'b1;
            end
            ST_EMIT:
                if (out_accept)
                begin
                    left_next  = left_reg - COUNT_W'(cnt);
                    index_next = alu_result;
                    if (last_result)
                        emitted_next = alu_result;
                end
            default:
            begin
            end
        endcase

        if (wr_en)
        begin
            unique case (wr_index)
                REG_PIXEL_BYTES_MODE: mode_next  = wr_data[1:0];
                REG_RLE_ENABLE:       rle_next   = wr_data[0];
                REG_PIXEL_TOTAL:      total_next = wr_data;
                default:
                begin
                end
            endcase
            if (wr_index == REG_PIXEL_BYTES_MODE || wr_index == REG_RLE_ENABLE ||
                wr_index == REG_PIXEL_TOTAL)
            begin
                expect_hdr_next  = 1'b1;
                is_run_next      = 1'b0;
                packet_left_next = '0;
                byte_pos_next    = '0;
                gather_next      = '0;
                emitted_next     = '0;
                finished_next    = 1'b0;
                overrun_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= MODE_THREE_BYTE;
            rle_reg         <= 1'b1;
            total_reg       <= '0;
            expect_hdr_reg  <= 1'b1;
            is_run_reg      <= 1'b0;
            packet_left_reg <= '0;
            byte_pos_reg    <= '0;
            gather_reg      <= '0;
            emitted_reg     <= '0;
            finished_reg    <= 1'b0;
            overrun_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            rle_reg         <= rle_next;
            total_reg       <= total_next;
            expect_hdr_reg  <= expect_hdr_next;
            is_run_reg      <= is_run_next;
            packet_left_reg <= packet_left_next;
            byte_pos_reg    <= byte_pos_next;
            gather_reg      <= gather_next;
            emitted_reg     <= emitted_next;
            finished_reg    <= finished_next;
            overrun_reg     <= overrun_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg   <= pix_next;
        room_reg  <= room_next;
        left_reg  <= left_next;
        index_reg <= index_next;
        reach_reg <= reach_next;
    end

    // Outputs.
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        out_valid    = (state_reg == ST_EMIT);
        first_pixel  = pix_reg;
        second_pixel = (cnt == 2'd2) ? pix_reg : 32'd0;
        pixel_count  = cnt;
        first_index  = index_reg;
        last_of_run  = last_result;
        image_done   = last_result && reach_reg;
        overrun      = overrun_reg;
    end

endmodule

`default_nettype wire
